/* hw/rtl/rsm_pkg.sv */
`default_nettype none
package rsm_pkg;
   localparam int unsigned CodeWidth = 64;
   localparam int unsigned TotalWidth = 7;
   localparam logic [CodeWidth-1:0] CodeAllOnes = {CodeWidth{1'b1}};

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SHIFT,
      ST_MREAD,
      ST_MSTEP,
      ST_EMIT
   } rsm_state_type;

   typedef struct packed {
      logic load_start;
      logic shift_step;
      logic shift_place;
      logic merge_init;
      logic merge_read;
      logic merge_step;
      logic emit_read;
      logic set_clear;
   } rsm_cmd_type;

   typedef struct packed {
      logic shift_done;
      logic store_full;
      logic merge_done;
      logic emit_done;
      logic rsp_busy;
   } rsm_status_type;
endpackage
`default_nettype wire

/* hw/rtl/rsm_ctrl.sv */
`default_nettype none
module rsm_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_range_last,
   output logic                        req_stall,
   input  wire rsm_pkg::rsm_status_type status,
   output rsm_pkg::rsm_cmd_type        cmd
);
   import rsm_pkg::*;

   rsm_state_type state_ff, state_in;
   logic last_ff, last_in;
   logic accept;

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff <= last_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      last_in = last_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               last_in = req_range_last;
               if (!status.store_full) state_in = ST_SHIFT;
               else if (req_range_last) state_in = ST_MREAD;
            end
         end
         ST_SHIFT: begin
            if (status.shift_done) state_in = last_ff ? ST_MREAD : ST_LOAD;
         end
         ST_MREAD: state_in = ST_MSTEP;
         ST_MSTEP: state_in = status.merge_done ? ST_EMIT : ST_MREAD;
         ST_EMIT: begin
            if (status.emit_done) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            cmd.load_start = accept && !status.store_full;
            cmd.merge_init = accept && status.store_full && req_range_last;
         end
         ST_SHIFT: begin
            cmd.shift_step = !status.shift_done;
            cmd.shift_place = status.shift_done;
            cmd.merge_init = status.shift_done && last_ff;
         end
         ST_MREAD: cmd.merge_read = 1'b1;
         ST_MSTEP: cmd.merge_step = 1'b1;
         ST_EMIT: begin
            cmd.emit_read = !status.rsp_busy;
            cmd.set_clear = status.emit_done;
         end
         default: cmd = '0;
      endcase
   end
endmodule
`default_nettype wire

/* hw/rtl/rsm_datapath.sv */
`default_nettype none
module rsm_datapath #(
   parameter int unsigned STORE_DEPTH = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [rsm_pkg::CodeWidth-1:0] req_range_start,
   input  wire logic [rsm_pkg::CodeWidth-1:0] req_range_end,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire rsm_pkg::rsm_cmd_type          cmd,
   output rsm_pkg::rsm_status_type            status,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [rsm_pkg::CodeWidth-1:0]      rsp_merged_start,
   output logic [rsm_pkg::CodeWidth-1:0]      rsp_merged_end,
   output logic                               rsp_merged_last,
   output logic [rsm_pkg::TotalWidth-1:0]     rsp_merged_total,
   output logic                               rsp_overflow_flag
);
   import rsm_pkg::*;

   localparam int unsigned IdxW = $clog2(STORE_DEPTH);
   localparam int unsigned CntW = $clog2(STORE_DEPTH + 1);
   localparam logic [CntW-1:0] CntMax = CntW'(STORE_DEPTH);

   logic [CodeWidth-1:0] s_mem [STORE_DEPTH];
   logic [CodeWidth-1:0] e_mem [STORE_DEPTH];

   logic [CntW-1:0] count_ff;
   logic            drop_ff;
   logic [CodeWidth-1:0] ins_s_ff, ins_e_ff;
   logic [CntW-1:0] pos_ff;
   logic [CodeWidth-1:0] rd_s_ff, rd_e_ff;
   logic            rd_ok_ff;
   logic [CntW-1:0] rd_idx_ff;
   logic [CntW-1:0] r_ff, w_ff;
   logic [CodeWidth-1:0] cur_s_ff, cur_e_ff;
   logic [CntW-1:0] emit_ff;
   logic            emit_pend_ff;

   logic [IdxW-1:0] rd_addr;
   logic            rd_en;
   logic            wr_en;
   logic [IdxW-1:0] wr_addr;
   logic [CodeWidth-1:0] wr_s, wr_e;
   logic            ins_less;
   logic            join_r;
   logic            rsp_take;
   logic [CntW-1:0] total;

   assign status.store_full = (count_ff == CntMax);
   assign ins_less = (ins_s_ff != rd_s_ff) ? (ins_s_ff < rd_s_ff) : (ins_e_ff < rd_e_ff);
   assign status.shift_done = rd_ok_ff && (pos_ff == '0 || !ins_less);
   assign status.merge_done = (r_ff + CntW'(1) >= count_ff);
   assign total = w_ff + CntW'(1);
   assign status.emit_done = emit_pend_ff && (emit_ff == total) && !rsp_valid;
   assign status.rsp_busy = (rsp_valid && rsp_stall) || (emit_ff == total);
   assign rsp_take = rsp_valid && !rsp_stall;

   assign join_r = (rd_s_ff <= cur_e_ff) ||
                   (cur_e_ff != CodeAllOnes && rd_s_ff == cur_e_ff + CodeWidth'(1));

   always_comb begin
      rd_en = 1'b0;
      rd_addr = '0;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_s = ins_s_ff;
      wr_e = ins_e_ff;
      if (cmd.load_start) begin
         rd_en = count_ff != '0;
         rd_addr = IdxW'(count_ff - CntW'(1));
      end else if (cmd.shift_step) begin
         wr_en = 1'b1;
         wr_addr = IdxW'(pos_ff);
         wr_s = rd_s_ff;
         wr_e = rd_e_ff;
         rd_en = pos_ff > CntW'(1);
         rd_addr = IdxW'(pos_ff - CntW'(2));
      end else if (cmd.shift_place) begin
         wr_en = 1'b1;
         wr_addr = IdxW'(pos_ff);
      end else if (cmd.merge_read) begin
         rd_en = 1'b1;
         rd_addr = IdxW'(r_ff);
      end else if (cmd.merge_step) begin
         if (r_ff != '0 && !join_r) begin
            wr_en = 1'b1;
            wr_addr = IdxW'(w_ff);
            wr_s = cur_s_ff;
            wr_e = cur_e_ff;
         end
      end else if (cmd.emit_read) begin
         rd_en = emit_ff != total;
         rd_addr = IdxW'(emit_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         s_mem[wr_addr] <= wr_s;
         e_mem[wr_addr] <= wr_e;
      end
      if (rd_en) begin
         rd_s_ff <= s_mem[rd_addr];
         rd_e_ff <= e_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         drop_ff <= 1'b0;
         rd_ok_ff <= 1'b0;
         emit_ff <= '0;
         emit_pend_ff <= 1'b0;
         rsp_valid <= 1'b0;
         pos_ff <= '0;
         r_ff <= '0;
         w_ff <= '0;
      end else begin
         if (req_valid && !req_stall && status.store_full) drop_ff <= 1'b1;
         if (cmd.load_start) begin
            ins_s_ff <= req_range_start;
            ins_e_ff <= req_range_end;
            pos_ff <= count_ff;
            rd_ok_ff <= 1'b1;
            count_ff <= count_ff + CntW'(1);
         end else if (cmd.shift_step) begin
            pos_ff <= pos_ff - CntW'(1);
         end
         if (cmd.merge_init) begin
            r_ff <= '0;
            w_ff <= '0;
            emit_ff <= '0;
            emit_pend_ff <= 1'b0;
         end
         if (cmd.merge_step) begin
            if (r_ff == '0) begin
               cur_s_ff <= rd_s_ff;
               cur_e_ff <= rd_e_ff;
            end else if (join_r) begin
               if (rd_e_ff > cur_e_ff) cur_e_ff <= rd_e_ff;
            end else begin
               w_ff <= w_ff + CntW'(1);
               cur_s_ff <= rd_s_ff;
               cur_e_ff <= rd_e_ff;
            end
            r_ff <= r_ff + CntW'(1);
         end
         if (cmd.emit_read && emit_ff != total) begin
            emit_ff <= emit_ff + CntW'(1);
            emit_pend_ff <= 1'b1;
            rsp_valid <= 1'b1;
            rsp_merged_last <= (emit_ff + CntW'(1) == total);
            rsp_merged_total <= TotalWidth'(total);
            rsp_overflow_flag <= drop_ff;
         end else if (rsp_take) begin
            rsp_valid <= 1'b0;
         end
         if (cmd.set_clear) begin
            count_ff <= '0;
            drop_ff <= 1'b0;
            emit_pend_ff <= 1'b0;
         end
      end
   end

   // the open range stays in cur_s_ff/cur_e_ff and is the last word
   always_comb begin
      rsp_merged_start = rd_s_ff;
      rsp_merged_end = rd_e_ff;
      if (rsp_merged_last) begin
         rsp_merged_start = cur_s_ff;
         rsp_merged_end = cur_e_ff;
      end
   end
endmodule
`default_nettype wire

/* hw/rtl/range_sort_merge_unit.sv */
`default_nettype none
// Channel | Dir | Ports
// req     | in  | req_valid, req_stall, req_range_start/end/last
// rsp     | out | rsp_valid, rsp_stall, rsp_merged_start/end/last/total, rsp_overflow_flag
// A stored range is sorted in by shifting larger stored ranges up one place; a full store drops it.
// The last word starts a merge that reads (MREAD) and then joins or writes back (MSTEP) each
// stored range on the one-read, one-write store, then one result per cycle, held while rsp_stall is high.
// Synchronous reset clears counts and control; the store holds no reset value.
module range_sort_merge_unit #(
   parameter int unsigned STORE_DEPTH = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [rsm_pkg::CodeWidth-1:0] req_range_start,
   input  wire logic [rsm_pkg::CodeWidth-1:0] req_range_end,
   input  wire logic                          req_range_last,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [rsm_pkg::CodeWidth-1:0]      rsp_merged_start,
   output logic [rsm_pkg::CodeWidth-1:0]      rsp_merged_end,
   output logic                               rsp_merged_last,
   output logic [rsm_pkg::TotalWidth-1:0]     rsp_merged_total,
   output logic                               rsp_overflow_flag
);
   import rsm_pkg::*;

   rsm_cmd_type    cmd;
   rsm_status_type status;

   rsm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_range_last(req_range_last), .req_stall(req_stall),
      .status(status), .cmd(cmd)
   );

   rsm_datapath #(.STORE_DEPTH(STORE_DEPTH)) u_dp (
      .clock(clock), .reset(reset),
      .req_range_start(req_range_start), .req_range_end(req_range_end),
      .req_valid(req_valid), .req_stall(req_stall),
      .cmd(cmd), .status(status),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_merged_start(rsp_merged_start), .rsp_merged_end(rsp_merged_end),
      .rsp_merged_last(rsp_merged_last), .rsp_merged_total(rsp_merged_total),
      .rsp_overflow_flag(rsp_overflow_flag)
   );

`ifndef SYNTHESIS
   a_no_accept_during_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input taken while emitting");
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_start, cmd.shift_step, cmd.merge_read, cmd.merge_step}))
      else $error("conflicting commands");
`endif
endmodule
`default_nettype wire
